// ===== rtl/elf64lpv_pkg.sv =====
// ---------------------------------------------------------------------------
// elf64lpv_pkg
// Shared types and constants for the ELF64 load plan validator.
// ---------------------------------------------------------------------------
package elf64lpv_pkg;

   // Size of the header window and the segment table limit.
   localparam int HEADER_WINDOW_BYTES = 4096;
   localparam int MAX_SEGMENTS        = 16;

   // Byte position counter: wide enough for the whole window, saturating.
   localparam int POS_W   = $clog2(HEADER_WINDOW_BYTES) + 1;
   localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);

   localparam logic [63:0] DIRECT_BASE = 64'hffff_ffff_8000_0000;
   localparam logic [63:0] PHYS_START  = 64'h0000_0000_0020_0000;
   localparam logic [63:0] PHYS_LIMIT  = 64'h0000_0000_0120_0000;
   localparam logic [5:0]  ENTRY_LAST  = 6'd55;
   localparam logic [7:0]  ENTRY_BYTES = 8'd56;

   // Result kinds.
   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_item_type;

   typedef struct packed {
      logic        record_kind;
      logic [63:0] file_offset;
      logic [63:0] phys_address;
      logic [63:0] file_bytes;
      logic [63:0] memory_bytes;
      logic [31:0] segment_flags;
      logic [63:0] entry_point;
      logic [63:0] span_start;
      logic [63:0] span_end;
      logic [4:0]  segments_found;
      logic        accepted;
      logic        last_of_run;
   } rsp_item_type;

   // Results produced by one byte: up to a record followed by a verdict.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   // Header byte expected at a given position; the flag is low where any value goes.
   function automatic logic [8:0] expected_byte(input logic [5:0] p);
      logic [8:0] r;
      r = 9'h000;
      case (p)
         6'd0:  r = {1'b1, 8'h7f};
         6'd1:  r = {1'b1, 8'h45};
         6'd2:  r = {1'b1, 8'h4c};
         6'd3:  r = {1'b1, 8'h46};
         6'd4:  r = {1'b1, 8'd2};
         6'd5:  r = {1'b1, 8'd1};
         6'd6:  r = {1'b1, 8'd1};
         6'd16: r = {1'b1, 8'd2};
         6'd18: r = {1'b1, 8'd62};
         6'd20: r = {1'b1, 8'd1};
         6'd17, 6'd19, 6'd21, 6'd22, 6'd23: r = {1'b1, 8'd0};
         6'd52: r = {1'b1, 8'd64};
         6'd54: r = {1'b1, 8'd56};
         6'd53, 6'd55: r = {1'b1, 8'd0};
         default: r = 9'h000;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/elf64lpv_core.sv =====
// ---------------------------------------------------------------------------
// elf64lpv_core
// Byte-wide header parser, program header assembly and load entry checks.
// ---------------------------------------------------------------------------
module elf64lpv_core
   import elf64lpv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  req_item_type item,
   input  logic [63:0]  size_limit,
   output push_type     push,
   output rsp_item_type res0,
   output rsp_item_type res1
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [63:0]        hentry_ff, hentry_in;
   logic [63:0]        toff_ff, toff_in;
   logic [15:0]        tents_ff, tents_in;
   logic               hgood_ff, hgood_in;
   logic [63:0]        ew_ff [7];
   logic [15:0]        seen_ff, seen_in;
   logic [63:0]        pend_ff, pend_in;
   logic [63:0]        low_ff, low_in;
   logic [63:0]        high_ff, high_in;
   logic [COUNT_W-1:0] lcnt_ff, lcnt_in;
   logic               exec_ff, exec_in;
   logic               vg_ff, vg_in;
   logic [5:0]         k_ff, k_in;

   // Working values, with a new image clearing them first.
   logic [POS_W-1:0]   c_pos;
   logic [63:0]        c_hentry, c_toff, c_pend, c_low, c_high;
   logic [15:0]        c_tents, c_seen;
   logic               c_hgood, c_exec, c_vg;
   logic [COUNT_W-1:0] c_lcnt;
   logic [5:0]         c_k;

   logic [7:0]  b;
   logic [8:0]  exp_b;
   logic [63:0] w0, off, va, pa, fsz, msz, al;
   logic [63:0] seg_end, va_end, lim_room, file_room;
   logic [13:0] tab_end;
   logic        load_fail, order_fail, is_load, in_table, last_k, hdr_fail, ok;
   logic [2:0]  wsel;
   logic [2:0]  lane;

   assign b = item.data_byte;

   always_comb begin
      if (item.first_byte) begin
         c_pos = '0; c_hentry = '0; c_toff = '0; c_tents = '0; c_hgood = 1'b1;
         c_seen = '0; c_pend = '0; c_low = '1; c_high = '0; c_lcnt = '0;
         c_exec = 1'b0; c_vg = 1'b0; c_k = '0;
      end else begin
         c_pos = pos_ff; c_hentry = hentry_ff; c_toff = toff_ff; c_tents = tents_ff;
         c_hgood = hgood_ff; c_seen = seen_ff; c_pend = pend_ff; c_low = low_ff;
         c_high = high_ff; c_lcnt = lcnt_ff; c_exec = exec_ff; c_vg = vg_ff;
         c_k = k_ff;
      end
   end

   // Program header words as seen on the last byte of an entry.
   assign w0  = ew_ff[0];
   assign off = ew_ff[1];
   assign va  = ew_ff[2];
   assign pa  = ew_ff[3];
   assign fsz = ew_ff[4];
   assign msz = ew_ff[5];
   assign al  = {b, ew_ff[6][55:0]};

   assign seg_end   = pa + msz;
   assign va_end    = va + msz;
   assign lim_room  = PHYS_LIMIT - pa;
   assign file_room = size_limit - off;
   assign is_load   = (w0[31:0] == 32'd1);

   // Load entry checks.
   always_comb begin
      load_fail = (c_lcnt >= COUNT_W'(MAX_SEGMENTS)) || (fsz > msz) || (msz == '0) ||
                  (pa < PHYS_START) || (pa >= PHYS_LIMIT) || (msz > lim_room) ||
                  (va != DIRECT_BASE + pa) || (pa[11:0] != 12'h000) ||
                  (al < 64'h1000) || ((al & (al - 64'd1)) != '0) ||
                  (off > size_limit) || (fsz > file_room);
      order_fail = (c_pend != '0) && (pa < c_pend);
   end

   // Table bounds check at the end of the file header.
   always_comb begin
      tab_end  = 14'(c_toff) + 14'(c_tents * ENTRY_BYTES);
      hdr_fail = !c_hgood || (c_tents == '0) || (c_tents > 16'(MAX_SEGMENTS)) ||
                 (c_toff < 64'd64) || (c_toff > 64'(HEADER_WINDOW_BYTES)) ||
                 (tab_end > 14'(HEADER_WINDOW_BYTES));
   end

   assign exp_b    = expected_byte(c_pos[5:0]);
   assign in_table = (c_pos >= 7'd64) && (c_pos >= c_toff[POS_W-1:0]);
   assign last_k   = (c_k == ENTRY_LAST);
   assign wsel     = c_k[5:3];
   assign lane     = c_k[2:0];

   // Next state and results for the accepted byte.
   always_comb begin
      pos_in = pos_ff; hentry_in = hentry_ff; toff_in = toff_ff; tents_in = tents_ff;
      hgood_in = hgood_ff; seen_in = seen_ff; pend_in = pend_ff; low_in = low_ff;
      high_in = high_ff; lcnt_in = lcnt_ff; exec_in = exec_ff; vg_in = vg_ff;
      k_in = k_ff;
      push = '0;
      ok = 1'b0;
      res0 = '0;
      res1 = '0;
      res1.record_kind = KIND_VERDICT;
      if (take) begin
         pos_in = c_pos; hentry_in = c_hentry; toff_in = c_toff; tents_in = c_tents;
         hgood_in = c_hgood; seen_in = c_seen; pend_in = c_pend; low_in = c_low;
         high_in = c_high; lcnt_in = c_lcnt; exec_in = c_exec; vg_in = c_vg;
         k_in = c_k;
         if (!c_vg) begin
            if (c_pos < 7'd64) begin
               // File header bytes.
               if (exp_b[8] && (b != exp_b[7:0])) begin
                  hgood_in = 1'b0;
               end
               if (c_pos[5:3] == 3'd3) begin
                  hentry_in[8*c_pos[2:0] +: 8] = b;
               end else if (c_pos[5:3] == 3'd4) begin
                  toff_in[8*c_pos[2:0] +: 8] = b;
               end else if (c_pos[5:1] == 5'd28) begin
                  tents_in[8*c_pos[0] +: 8] = b;
               end
               if ((c_pos[5:0] == 6'd63) && hdr_fail) begin
                  res0.record_kind = KIND_VERDICT;
                  res0.last_of_run = 1'b1;
                  push.first       = 1'b1;
                  vg_in            = 1'b1;
               end
            end else if (in_table) begin
               // Program header bytes.
               k_in = last_k ? '0 : c_k + 6'd1;
               if (last_k) begin
                  if (is_load && (load_fail || order_fail)) begin
                     res0.record_kind = KIND_VERDICT;
                     res0.last_of_run = 1'b1;
                     push.first       = 1'b1;
                     vg_in            = 1'b1;
                  end else begin
                     if (is_load) begin
                        pend_in = seg_end;
                        lcnt_in = c_lcnt + 1'b1;
                        if (pa < c_low) begin
                           low_in = pa;
                        end
                        if (seg_end > c_high) begin
                           high_in = seg_end;
                        end
                        if (w0[32] && (c_hentry >= va) && (c_hentry < va_end)) begin
                           exec_in = 1'b1;
                        end
                        // A record on its own is the last result of its byte.
                        res0.record_kind   = KIND_SEGMENT;
                        res0.file_offset   = off;
                        res0.phys_address  = pa;
                        res0.file_bytes    = fsz;
                        res0.memory_bytes  = msz;
                        res0.segment_flags = w0[63:32];
                        res0.last_of_run   = 1'b1;
                        push.first         = 1'b1;
                     end
                     seen_in = c_seen + 16'd1;
                     if (seen_in >= c_tents) begin
                        ok = (lcnt_in != '0) && exec_in && (low_in == PHYS_START);
                        vg_in = 1'b1;
                        if (ok) begin
                           res1.entry_point    = c_hentry;
                           res1.span_start     = low_in;
                           res1.span_end       = high_in;
                           res1.segments_found = 5'(lcnt_in);
                           res1.accepted       = 1'b1;
                        end
                        res1.last_of_run = 1'b1;
                        if (is_load) begin
                           res0.last_of_run = 1'b0;
                           push.second      = 1'b1;
                        end else begin
                           res0        = res1;
                           push.first  = 1'b1;
                        end
                     end
                  end
               end
            end
            if (c_pos != '1) begin
               pos_in = c_pos + 1'b1;
            end
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; hentry_ff <= '0; toff_ff <= '0; tents_ff <= '0;
         hgood_ff <= 1'b1; seen_ff <= '0; pend_ff <= '0; low_ff <= '1;
         high_ff <= '0; lcnt_ff <= '0; exec_ff <= 1'b0; vg_ff <= 1'b1; k_ff <= '0;
      end else begin
         pos_ff <= pos_in; hentry_ff <= hentry_in; toff_ff <= toff_in;
         tents_ff <= tents_in; hgood_ff <= hgood_in; seen_ff <= seen_in;
         pend_ff <= pend_in; low_ff <= low_in; high_ff <= high_in;
         lcnt_ff <= lcnt_in; exec_ff <= exec_in; vg_ff <= vg_in; k_ff <= k_in;
      end
   end

   // Program header word assembly; every byte is rewritten before use.
   always_ff @(posedge clock) begin
      if (take && !c_vg && (c_pos >= 7'd64) && in_table) begin
         ew_ff[wsel][8*lane +: 8] <= b;
      end
   end

endmodule

// ===== rtl/elf64lpv_rsp_queue.sv =====
// ---------------------------------------------------------------------------
// elf64lpv_rsp_queue
// Four-entry result queue taking up to two items per cycle.
// ---------------------------------------------------------------------------
module elf64lpv_rsp_queue
   import elf64lpv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  rsp_item_type res0,
   input  rsp_item_type res1,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   rsp_item_type slot_ff [4];
   logic [1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;
   logic [2:0]   npush;

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_item  = slot_ff[head_ff];
   assign room      = (count_ff <= 3'd2);
   assign pop       = rsp_valid && rsp_ready;
   assign npush     = {2'b00, push.first} + {2'b00, push.second};

   // Pointer and fill count update.
   always_comb begin
      head_in  = pop ? head_ff + 2'd1 : head_ff;
      tail_in  = tail_ff + npush[1:0];
      count_in = count_ff + npush - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // A single result goes in at the tail; a pair fills tail and the slot after it.
   always_ff @(posedge clock) begin
      if (push.first) begin
         slot_ff[tail_ff] <= res0;
      end
      if (push.second) begin
         slot_ff[tail_ff + 2'd1] <= res1;
      end
   end

endmodule

// ===== rtl/elf64_load_plan_validator_unit.sv =====
// ---------------------------------------------------------------------------
// elf64_load_plan_validator_unit
// Checks an ELF64 header and its program headers and lists the load segments.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake              Carries
// req_      in         req_valid / req_ready  one header window byte per item
// rsp_      out        rsp_valid / rsp_ready  segment record or final verdict
// csr_      in         csr_valid / csr_ready  file size limit
//
// One byte is taken per cycle while req_ready is high; the parser and entry
// checks sit between the state registers and a four-entry result queue.
// Results of a byte are offered from the cycle after the byte is taken.
// A byte can give two results; req_ready drops while fewer than two queue
// slots are free, so the queue depth sets how long the sink may stall.
// Reset is synchronous; after it the unit ignores bytes until a first byte.
module elf64_load_plan_validator_unit
   import elf64lpv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [63:0]  csr_data
);

   logic [63:0]  fsl_ff;
   logic         room;
   logic         take;
   push_type     push;
   rsp_item_type res0, res1;

   assign csr_ready = 1'b1;
   assign req_ready = room;
   assign take      = req_valid && room;

   // File size limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsl_ff <= '0;
      end else if (csr_valid) begin
         fsl_ff <= csr_data;
      end
   end

   elf64lpv_core u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .item       (req_item),
      .size_limit (fsl_ff),
      .push       (push),
      .res0       (res0),
      .res1       (res1)
   );

   elf64lpv_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .res0      (res0),
      .res1      (res1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
